// File: rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and constants of the multilevel round-robin scheduler.
// ----------------------------------------------------------------------------
package mrr_pkg;

   localparam int ID_W    = 6;
   localparam int LEVEL_W = 4;
   localparam int SLICE_W = 8;

   localparam logic [SLICE_W-1:0] BOOT_SLICE = 8'd2;
   localparam logic [SLICE_W-1:0] IDLE_SLICE = 8'd1;

   // command codes of an input item
   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_SLEEP = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   // per-slot task state
   typedef enum logic [1:0] {
      TS_FREE  = 2'd0,
      TS_SLEEP = 2'd1,
      TS_RUN   = 2'd2
   } tstate_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_SLOT = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_CLR,
      S_IDLE,
      S_A_RD,
      S_A_CHK,
      S_T_RD,
      S_T_CHK,
      S_SL_CUR,
      S_SL_BEF,
      S_RM_RD,
      S_RM_CHK,
      S_RM_END,
      S_ADD,
      S_TK_CUR,
      S_TK_BEF,
      S_PICK,
      S_O_RD,
      S_O_TK,
      S_O_DONE
   } fsm_type;

endpackage

// File: rtl/mrr_if.sv
// ----------------------------------------------------------------------------
// mrr_req_if / mrr_rsp_if
// Valid/ready channels carrying scheduler commands and scheduler results.
// ----------------------------------------------------------------------------
interface mrr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             command;
   logic [mrr_pkg::ID_W-1:0]               task_id;
   logic signed [mrr_pkg::LEVEL_W-1:0]     level;
   logic [mrr_pkg::SLICE_W-1:0]            priority_req;

   modport source (output valid, command, task_id, level, priority_req, input ready);
   modport sink   (input valid, command, task_id, level, priority_req, output ready);
endinterface

interface mrr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mrr_pkg::ID_W-1:0]       current_task;
   logic                           current_valid;
   logic [mrr_pkg::SLICE_W-1:0]    timer_reload;
   logic                           switched;
   logic [mrr_pkg::ID_W-1:0]       alloc_task;
   logic [1:0]                     status;

   modport source (output valid, current_task, current_valid, timer_reload, switched,
                   alloc_task, status, input ready);
   modport sink   (input valid, current_task, current_valid, timer_reload, switched,
                   alloc_task, status, output ready);
endinterface

// File: rtl/multilevel_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_round_robin_scheduler
// Task scheduler with priority levels, each served round-robin. A small
// sequencer walks a task memory and a level list memory one entry at a time.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_chan  in    valid/ready    command, task_id, level, priority_req
//  rsp_chan  out   valid/ready    current_task, current_valid, timer_reload,
//                                 switched, alloc_task, status
//
//  one item at a time; allocate scans the task slots in turn, and a moving run
//  or a sleep scans the list entries of the old level in turn
//  after reset a clearing pass over the NUM_TASKS slots fills the task memory
//  and the boot list entries; no item is taken meanwhile
//  a finished result waits in the output register while the next item is
//  taken; a result still held there when the next one is done stalls it
// ----------------------------------------------------------------------------
module multilevel_round_robin_scheduler #(
   parameter int NUM_TASKS   = 64,
   parameter int NUM_LEVELS  = 8,
   parameter int LEVEL_SLOTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   mrr_req_if.sink          req_chan,
   mrr_rsp_if.source        rsp_chan
);

   localparam int TW  = $clog2(NUM_TASKS);
   localparam int LW  = $clog2(NUM_LEVELS);
   localparam int SW  = $clog2(LEVEL_SLOTS);
   localparam int CW  = $clog2(LEVEL_SLOTS + 1);
   localparam int LA  = LW + SW;
   localparam int TWD = 2 + LW + mrr_pkg::SLICE_W;

   // memories
   logic [TWD-1:0] task_mem [NUM_TASKS];
   logic [TW-1:0]  list_mem [2**LA];

   logic           task_we;
   logic [TW-1:0]  task_wa, task_ra;
   logic [TWD-1:0] task_wd, task_q;
   logic           list_we;
   logic [LA-1:0]  list_wa, list_ra;
   logic [TW-1:0]  list_wd, list_q;

   // level bookkeeping
   logic [CW-1:0]  cnt_ff [NUM_LEVELS];
   logic [SW-1:0]  cur_ff [NUM_LEVELS];
   logic [LW-1:0]  act_ff;
   logic           chg_ff;

   // sequencer and item registers
   mrr_pkg::fsm_type state_ff, state_in;
   mrr_pkg::cmd_type cmd_ff;
   logic [mrr_pkg::ID_W-1:0]    id_ff;
   logic [mrr_pkg::LEVEL_W-1:0] lvl_ff;
   logic [mrr_pkg::SLICE_W-1:0] prio_ff;
   logic [TW-1:0]  scan_ff;
   logic [LW-1:0]  newlv_ff, oldlv_ff;
   logic [CW-1:0]  k_ff;
   logic [SW-1:0]  pos_ff;
   logic           found_ff, had_ff, hit_ff, valid_ff;
   logic [TW-1:0]  before_ff, ctask_ff;
   logic           sw_ff;
   mrr_pkg::status_type stat_ff;
   logic [mrr_pkg::ID_W-1:0] alloc_ff;

   // result register
   logic                        rsp_valid_ff;
   logic [mrr_pkg::ID_W-1:0]    o_task_ff, o_alloc_ff;
   logic                        o_valid_ff, o_sw_ff;
   logic [mrr_pkg::SLICE_W-1:0] o_reload_ff;
   mrr_pkg::status_type         o_stat_ff;

   // decode of the task word read back
   mrr_pkg::tstate_type          q_st;
   logic [LW-1:0]                q_lv;
   logic [mrr_pkg::SLICE_W-1:0]  q_sl;
   logic [LW-1:0]  run_lv, lsel, pick;
   logic           moves, adds, full, id_ok, cnt_nz;
   logic [TW-1:0]  idt, ctask;
   logic [CW-1:0]  cnt_rd;
   logic [SW-1:0]  cur_rd, cfix;
   logic           cnt_we, cur_we;
   logic [CW-1:0]  cnt_wd, n_dec;
   logic [SW-1:0]  cur_wd, c_adj;
   logic [CW-1:0]  c_inc;
   logic           accept;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == mrr_pkg::S_IDLE);

   assign q_st  = mrr_pkg::tstate_type'(task_q[TWD-1 -: 2]);
   assign q_lv  = task_q[mrr_pkg::SLICE_W +: LW];
   assign q_sl  = task_q[mrr_pkg::SLICE_W-1:0];
   assign id_ok = 32'(id_ff) < NUM_TASKS;
   assign idt   = TW'(id_ff);

   // requested level, negative keeps, too high saturates
   always_comb begin
      if (lvl_ff[3]) begin
         run_lv = q_lv;
      end else if (32'(lvl_ff[2:0]) >= NUM_LEVELS) begin
         run_lv = LW'(NUM_LEVELS - 1);
      end else begin
         run_lv = LW'(lvl_ff[2:0]);
      end
   end

   assign moves = (q_st == mrr_pkg::TS_RUN) && (q_lv != run_lv);
   assign adds  = (q_st != mrr_pkg::TS_RUN) || moves;

   // level selected for the single count/cursor port
   always_comb begin
      case (state_ff)
         mrr_pkg::S_T_CHK:  lsel = run_lv;
         mrr_pkg::S_RM_RD,
         mrr_pkg::S_RM_CHK,
         mrr_pkg::S_RM_END: lsel = oldlv_ff;
         mrr_pkg::S_ADD:    lsel = newlv_ff;
         default:           lsel = act_ff;
      endcase
   end

   assign cnt_rd = cnt_ff[lsel];
   assign cur_rd = cur_ff[lsel];
   assign cnt_nz = cnt_rd != '0;
   assign full   = adds && (32'(cnt_rd) >= LEVEL_SLOTS);
   assign cfix   = (CW'(cur_rd) >= cnt_rd) ? '0 : cur_rd;
   assign ctask  = valid_ff ? list_q : '0;
   assign n_dec  = cnt_rd - CW'(1);
   assign c_inc  = CW'(cur_rd) + CW'(1);

   // cursor after a removal
   always_comb begin
      c_adj = cur_rd;
      if (pos_ff < cur_rd) begin
         c_adj = cur_rd - SW'(1);
      end
      if (CW'(c_adj) >= n_dec) begin
         c_adj = '0;
      end
   end

   // first non-empty level, level 0 when all are empty
   always_comb begin
      pick = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            pick = LW'(i);
         end
      end
   end

   // task memory
   always_ff @(posedge clock) begin
      if (task_we) begin
         task_mem[task_wa] <= task_wd;
      end
      task_q <= task_mem[task_ra];
   end

   // level list memory
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
      list_q <= list_mem[list_ra];
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrr_pkg::S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and memory controls
   always_comb begin
      state_in = state_ff;
      task_we  = 1'b0;
      task_wa  = scan_ff;
      task_wd  = '0;
      task_ra  = scan_ff;
      list_we  = 1'b0;
      list_wa  = '0;
      list_wd  = '0;
      list_ra  = {act_ff, cfix};
      cnt_we   = 1'b0;
      cnt_wd   = cnt_rd;
      cur_we   = 1'b0;
      cur_wd   = cur_rd;
      case (state_ff)
         mrr_pkg::S_CLR: begin
            task_we = 1'b1;
            if (scan_ff == TW'(0)) begin
               task_wd = {mrr_pkg::TS_RUN, LW'(0), mrr_pkg::BOOT_SLICE};
               list_we = 1'b1;
               list_wa = '0;
               list_wd = TW'(0);
            end else if (scan_ff == TW'(1)) begin
               task_wd = {mrr_pkg::TS_RUN, LW'(NUM_LEVELS - 1), mrr_pkg::IDLE_SLICE};
               list_we = 1'b1;
               list_wa = {LW'(NUM_LEVELS - 1), SW'(0)};
               list_wd = TW'(1);
            end else begin
               task_wd = {mrr_pkg::TS_FREE, LW'(0), 8'd0};
            end
            if (scan_ff == TW'(NUM_TASKS - 1)) begin
               state_in = mrr_pkg::S_IDLE;
            end
         end
         mrr_pkg::S_IDLE: begin
            if (accept) begin
               case (mrr_pkg::cmd_type'(req_chan.command))
                  mrr_pkg::CMD_ALLOC: state_in = mrr_pkg::S_A_RD;
                  mrr_pkg::CMD_TICK:  state_in = mrr_pkg::S_TK_CUR;
                  default:            state_in = mrr_pkg::S_T_RD;
               endcase
            end
         end
         // allocate: scan for the lowest free slot
         mrr_pkg::S_A_RD: begin
            state_in = mrr_pkg::S_A_CHK;
         end
         mrr_pkg::S_A_CHK: begin
            if (q_st == mrr_pkg::TS_FREE) begin
               task_we  = 1'b1;
               task_wd  = {mrr_pkg::TS_SLEEP, q_lv, q_sl};
               state_in = mrr_pkg::S_O_RD;
            end else if (scan_ff == TW'(NUM_TASKS - 1)) begin
               state_in = mrr_pkg::S_O_RD;
            end else begin
               state_in = mrr_pkg::S_A_RD;
            end
         end
         // run and sleep: fetch the task word
         mrr_pkg::S_T_RD: begin
            task_ra  = idt;
            state_in = id_ok ? mrr_pkg::S_T_CHK : mrr_pkg::S_O_RD;
         end
         mrr_pkg::S_T_CHK: begin
            task_wa  = idt;
            state_in = mrr_pkg::S_O_RD;
            if (cmd_ff == mrr_pkg::CMD_RUN) begin
               if (q_st != mrr_pkg::TS_FREE && !full) begin
                  task_we = 1'b1;
                  task_wd = {adds ? mrr_pkg::TS_RUN : q_st, adds ? run_lv : q_lv,
                             (prio_ff != '0) ? prio_ff : q_sl};
                  if (moves) begin
                     state_in = mrr_pkg::S_RM_RD;
                  end else if (adds) begin
                     state_in = mrr_pkg::S_ADD;
                  end
               end
            end else if (q_st == mrr_pkg::TS_RUN) begin
               task_we  = 1'b1;
               task_wd  = {mrr_pkg::TS_SLEEP, q_lv, q_sl};
               state_in = mrr_pkg::S_SL_CUR;
            end
         end
         mrr_pkg::S_SL_CUR: begin
            state_in = mrr_pkg::S_SL_BEF;
         end
         mrr_pkg::S_SL_BEF: begin
            state_in = mrr_pkg::S_RM_RD;
         end
         // removal: search the list and close the gap
         mrr_pkg::S_RM_RD: begin
            list_ra  = {oldlv_ff, k_ff[SW-1:0]};
            state_in = (k_ff == cnt_rd) ? mrr_pkg::S_RM_END : mrr_pkg::S_RM_CHK;
         end
         mrr_pkg::S_RM_CHK: begin
            if (found_ff) begin
               list_we = 1'b1;
               list_wa = {oldlv_ff, SW'(k_ff - CW'(1))};
               list_wd = list_q;
            end
            state_in = mrr_pkg::S_RM_RD;
         end
         mrr_pkg::S_RM_END: begin
            if (found_ff) begin
               cnt_we = 1'b1;
               cnt_wd = n_dec;
               cur_we = 1'b1;
               cur_wd = c_adj;
            end
            if (cmd_ff == mrr_pkg::CMD_RUN) begin
               state_in = mrr_pkg::S_ADD;
            end else begin
               state_in = hit_ff ? mrr_pkg::S_PICK : mrr_pkg::S_O_RD;
            end
         end
         // append at the tail of the new level
         mrr_pkg::S_ADD: begin
            list_we  = 1'b1;
            list_wa  = {newlv_ff, SW'(cnt_rd)};
            list_wd  = idt;
            cnt_we   = 1'b1;
            cnt_wd   = cnt_rd + CW'(1);
            state_in = mrr_pkg::S_O_RD;
         end
         mrr_pkg::S_TK_CUR: begin
            state_in = mrr_pkg::S_TK_BEF;
         end
         // advance the cursor of the active level
         mrr_pkg::S_TK_BEF: begin
            if (cnt_nz) begin
               cur_we = 1'b1;
               cur_wd = (c_inc >= cnt_rd) ? '0 : SW'(c_inc);
            end
            state_in = mrr_pkg::S_O_RD;
         end
         mrr_pkg::S_PICK: begin
            state_in = mrr_pkg::S_O_RD;
         end
         // result: current task and its slice
         mrr_pkg::S_O_RD: begin
            state_in = mrr_pkg::S_O_TK;
         end
         mrr_pkg::S_O_TK: begin
            task_ra  = ctask;
            state_in = mrr_pkg::S_O_DONE;
         end
         // keep the current task word on the read port while the result waits
         mrr_pkg::S_O_DONE: begin
            task_ra = ctask_ff;
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = mrr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mrr_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_ff[i] <= (i == 0 || i == NUM_LEVELS - 1) ? CW'(1) : '0;
            cur_ff[i] <= '0;
         end
         act_ff       <= '0;
         chg_ff       <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cnt_we) begin
            cnt_ff[lsel] <= cnt_wd;
         end
         if (cur_we) begin
            cur_ff[lsel] <= cur_wd;
         end
         case (state_ff)
            mrr_pkg::S_CLR: begin
               scan_ff <= scan_ff + TW'(1);
            end
            mrr_pkg::S_IDLE: begin
               scan_ff <= '0;
            end
            mrr_pkg::S_A_CHK: begin
               if (q_st != mrr_pkg::TS_FREE && scan_ff != TW'(NUM_TASKS - 1)) begin
                  scan_ff <= scan_ff + TW'(1);
               end
            end
            mrr_pkg::S_T_CHK: begin
               if (cmd_ff == mrr_pkg::CMD_RUN && q_st != mrr_pkg::TS_FREE && !full) begin
                  chg_ff <= 1'b1;
               end
            end
            mrr_pkg::S_TK_BEF: begin
               if (chg_ff) begin
                  act_ff <= pick;
                  chg_ff <= 1'b0;
               end
            end
            mrr_pkg::S_PICK: begin
               act_ff <= pick;
               chg_ff <= 1'b0;
            end
            default: begin
            end
         endcase
         if (state_ff == mrr_pkg::S_O_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result registers
   always_ff @(posedge clock) begin
      case (state_ff)
         mrr_pkg::S_IDLE: begin
            if (accept) begin
               cmd_ff   <= mrr_pkg::cmd_type'(req_chan.command);
               id_ff    <= req_chan.task_id;
               lvl_ff   <= req_chan.level;
               prio_ff  <= req_chan.priority_req;
               stat_ff  <= mrr_pkg::STAT_OK;
               alloc_ff <= '0;
               hit_ff   <= 1'b0;
               had_ff   <= 1'b0;
               found_ff <= 1'b0;
               k_ff     <= '0;
               pos_ff   <= '0;
            end
         end
         mrr_pkg::S_A_CHK: begin
            if (q_st == mrr_pkg::TS_FREE) begin
               alloc_ff <= mrr_pkg::ID_W'(scan_ff);
            end else if (scan_ff == TW'(NUM_TASKS - 1)) begin
               stat_ff <= mrr_pkg::STAT_NO_SLOT;
            end
         end
         mrr_pkg::S_T_CHK: begin
            newlv_ff <= run_lv;
            oldlv_ff <= q_lv;
            if (cmd_ff == mrr_pkg::CMD_RUN && q_st != mrr_pkg::TS_FREE && full) begin
               stat_ff <= mrr_pkg::STAT_FULL;
            end
         end
         mrr_pkg::S_SL_CUR, mrr_pkg::S_TK_CUR: begin
            had_ff <= cnt_nz;
         end
         mrr_pkg::S_SL_BEF: begin
            before_ff <= list_q;
            hit_ff    <= had_ff && (list_q == idt);
         end
         mrr_pkg::S_TK_BEF: begin
            before_ff <= list_q;
         end
         mrr_pkg::S_RM_CHK: begin
            if (!found_ff && list_q == idt) begin
               found_ff <= 1'b1;
               pos_ff   <= k_ff[SW-1:0];
            end
            k_ff <= k_ff + CW'(1);
         end
         mrr_pkg::S_O_RD: begin
            valid_ff <= cnt_nz;
         end
         mrr_pkg::S_O_TK: begin
            ctask_ff <= ctask;
            case (cmd_ff)
               mrr_pkg::CMD_SLEEP: sw_ff <= hit_ff && valid_ff;
               mrr_pkg::CMD_TICK:  sw_ff <= valid_ff && (!had_ff || list_q != before_ff);
               default:            sw_ff <= 1'b0;
            endcase
         end
         mrr_pkg::S_O_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               o_task_ff   <= mrr_pkg::ID_W'(ctask_ff);
               o_valid_ff  <= valid_ff;
               o_reload_ff <= valid_ff ? q_sl : '0;
               o_sw_ff     <= sw_ff;
               o_alloc_ff  <= alloc_ff;
               o_stat_ff   <= stat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.current_task  = o_task_ff;
   assign rsp_chan.current_valid = o_valid_ff;
   assign rsp_chan.timer_reload  = o_reload_ff;
   assign rsp_chan.switched      = o_sw_ff;
   assign rsp_chan.alloc_task    = o_alloc_ff;
   assign rsp_chan.status        = o_stat_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff[act_ff]) <= LEVEL_SLOTS)
      else $error("active level count above list size");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      cur_ff[act_ff] == '0 || CW'(cur_ff[act_ff]) < cnt_ff[act_ff])
      else $error("active cursor beyond list");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !o_valid_ff |-> o_task_ff == '0 && o_reload_ff == '0)
      else $error("empty result carries a task");

   a_switch_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_sw_ff |-> o_valid_ff)
      else $error("switch issued without a task");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != mrr_pkg::S_IDLE)
      else $error("sequencer idle after taking an item");

endmodule
